/* rtl/core/ctsc_pkg.sv */
// Shared types and constants of the C-style token scanner.
package ctsc_pkg;

  localparam logic [3:0] MAX_FRACTION_DIGITS = 4'd9;
  localparam int         QUEUE_DEPTH         = 4;
  localparam int         QPTR_W              = $clog2(QUEUE_DEPTH);
  localparam int         QCNT_W              = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_WORD, S_DEC, S_FRAC, S_ZERO, S_OCT, S_HEX, S_LINE, S_BLOCK,
    S_PLUS, S_MINUS, S_STAR, S_SLASH, S_PERCENT, S_EQ, S_BANG, S_GT, S_GTGT,
    S_LT, S_LTLT, S_AMP, S_BAR, S_CARET, S_DOT, S_HASH
  } state_t;

  typedef logic [5:0] kind_t;

  localparam kind_t K_END         = 6'd0;
  localparam kind_t K_WORD        = 6'd1;
  localparam kind_t K_INT         = 6'd2;
  localparam kind_t K_REAL        = 6'd3;
  localparam kind_t K_TILDE       = 6'd4;
  localparam kind_t K_SEMI        = 6'd5;
  localparam kind_t K_QUEST       = 6'd6;
  localparam kind_t K_COLON       = 6'd7;
  localparam kind_t K_COMMA       = 6'd8;
  localparam kind_t K_LBRACE      = 6'd9;
  localparam kind_t K_RBRACE      = 6'd10;
  localparam kind_t K_LBRACK      = 6'd11;
  localparam kind_t K_RBRACK      = 6'd12;
  localparam kind_t K_LPAREN      = 6'd13;
  localparam kind_t K_RPAREN      = 6'd14;
  localparam kind_t K_ADD         = 6'd15;
  localparam kind_t K_INC         = 6'd16;
  localparam kind_t K_ADDA        = 6'd17;
  localparam kind_t K_SUB         = 6'd18;
  localparam kind_t K_DEC         = 6'd19;
  localparam kind_t K_SUBA        = 6'd20;
  localparam kind_t K_MUL         = 6'd21;
  localparam kind_t K_MULA        = 6'd22;
  localparam kind_t K_DIV         = 6'd23;
  localparam kind_t K_DIVA        = 6'd24;
  localparam kind_t K_MOD         = 6'd25;
  localparam kind_t K_MODA        = 6'd26;
  localparam kind_t K_ASSIGN      = 6'd27;
  localparam kind_t K_EQUAL       = 6'd28;
  localparam kind_t K_NOT         = 6'd29;
  localparam kind_t K_NEQ         = 6'd30;
  localparam kind_t K_GT          = 6'd31;
  localparam kind_t K_GE          = 6'd32;
  localparam kind_t K_SHR         = 6'd33;
  localparam kind_t K_SHRA        = 6'd34;
  localparam kind_t K_LT          = 6'd35;
  localparam kind_t K_LE          = 6'd36;
  localparam kind_t K_SHL         = 6'd37;
  localparam kind_t K_SHLA        = 6'd38;
  localparam kind_t K_BAND        = 6'd39;
  localparam kind_t K_LAND        = 6'd40;
  localparam kind_t K_BANDA       = 6'd41;
  localparam kind_t K_BOR         = 6'd42;
  localparam kind_t K_LOR         = 6'd43;
  localparam kind_t K_BORA        = 6'd44;
  localparam kind_t K_XOR         = 6'd45;
  localparam kind_t K_XORA        = 6'd46;
  localparam kind_t K_DOT         = 6'd47;
  localparam kind_t K_HASH        = 6'd48;
  localparam kind_t K_GLUE        = 6'd49;
  localparam kind_t K_ERR_CHAR    = 6'd50;
  localparam kind_t K_ERR_COMMENT = 6'd51;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [3:0]  scale;
    logic [7:0]  word_length;
  } token_t;

  typedef struct packed {
    state_t      st;
    logic [31:0] acc;
    logic        neg;
    logic [3:0]  frac;
    logic [7:0]  wcnt;
    logic        pws;
  } scan_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } qword_t;

  localparam scan_t SCAN_IDLE = '{st: S_IDLE, acc: 32'd0, neg: 1'b0, frac: 4'd0,
                                  wcnt: 8'd0, pws: 1'b0};

endpackage

/* rtl/core/ctsc_scanner.sv */
// One scanner step: next scan state and up to two tokens for one character word.
module ctsc_scanner (
  input  ctsc_pkg::scan_t  cur,
  input  logic [7:0]       ch,
  input  logic             eos,
  output ctsc_pkg::scan_t  nxt,
  output ctsc_pkg::token_t tok0,
  output ctsc_pkg::token_t tok1,
  output logic [1:0]       tok_n
);
  import ctsc_pkg::*;

  typedef struct packed {
    logic       h1;
    logic [7:0] c1;
    kind_t      k1;
    logic       h2;
    logic [7:0] c2;
    kind_t      k2;
    kind_t      alone;
  } op_rule_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } opt_tok_t;

  typedef struct packed {
    scan_t    sc;
    opt_tok_t ot;
  } start_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_", "$"};
  endfunction

  function automatic opt_tok_t mk_tok(input kind_t k, input logic [31:0] v);
    opt_tok_t r;
    r.valid = 1'b1;
    r.tok   = '{kind: k, value: v, scale: 4'd0, word_length: 8'd0};
    return r;
  endfunction

  // Multiply-accumulate by the radix with shifts and adds only.
  function automatic logic [31:0] mac10(input logic [31:0] a, input logic [3:0] d);
    return {a[28:0], 3'b000} + {a[30:0], 1'b0} + {28'd0, d};
  endfunction

  function automatic op_rule_t op_rule(input state_t s);
    op_rule_t r;
    r = '{h1: 1'b0, c1: 8'd0, k1: K_END, h2: 1'b0, c2: 8'd0, k2: K_END, alone: K_END};
    case (s)
      S_PLUS:    r = '{1'b1, "+", K_INC,   1'b1, "=", K_ADDA,  K_ADD};
      S_MINUS:   r = '{1'b1, "-", K_DEC,   1'b1, "=", K_SUBA,  K_SUB};
      S_STAR:    r = '{1'b1, "=", K_MULA,  1'b0, 8'd0, K_END,  K_MUL};
      S_SLASH:   r = '{1'b1, "=", K_DIVA,  1'b0, 8'd0, K_END,  K_DIV};
      S_PERCENT: r = '{1'b1, "=", K_MODA,  1'b0, 8'd0, K_END,  K_MOD};
      S_EQ:      r = '{1'b1, "=", K_EQUAL, 1'b0, 8'd0, K_END,  K_ASSIGN};
      S_BANG:    r = '{1'b1, "=", K_NEQ,   1'b0, 8'd0, K_END,  K_NOT};
      S_GT:      r = '{1'b1, "=", K_GE,    1'b0, 8'd0, K_END,  K_GT};
      S_GTGT:    r = '{1'b1, "=", K_SHRA,  1'b0, 8'd0, K_END,  K_SHR};
      S_LT:      r = '{1'b1, "=", K_LE,    1'b0, 8'd0, K_END,  K_LT};
      S_LTLT:    r = '{1'b1, "=", K_SHLA,  1'b0, 8'd0, K_END,  K_SHL};
      S_AMP:     r = '{1'b1, "&", K_LAND,  1'b1, "=", K_BANDA, K_BAND};
      S_BAR:     r = '{1'b1, "|", K_LOR,   1'b1, "=", K_BORA,  K_BOR};
      S_CARET:   r = '{1'b1, "=", K_XORA,  1'b0, 8'd0, K_END,  K_XOR};
      S_DOT:     r = '{1'b0, 8'd0, K_END,  1'b0, 8'd0, K_END,  K_DOT};
      S_HASH:    r = '{1'b1, "#", K_GLUE,  1'b0, 8'd0, K_END,  K_HASH};
      default:   r = r;
    endcase
    return r;
  endfunction

  // Token left pending in a scan state when a non-continuing character arrives.
  function automatic opt_tok_t flush_tok(input scan_t sc, input state_t s);
    opt_tok_t    r;
    logic [31:0] sv;
    op_rule_t    rl;
    sv = sc.neg ? (32'd0 - sc.acc) : sc.acc;
    rl = op_rule(s);
    r  = '0;
    case (s)
      S_IDLE, S_LINE: r = '0;
      S_WORD: begin
        r = mk_tok(K_WORD, 32'd0);
        r.tok.word_length = sc.wcnt;
      end
      S_DEC, S_ZERO, S_OCT, S_HEX: r = mk_tok(K_INT, sv);
      S_FRAC: begin
        r = mk_tok(K_REAL, sv);
        r.tok.scale = sc.frac;
      end
      S_BLOCK: r = mk_tok(K_ERR_COMMENT, 32'd0);
      default: r = mk_tok(rl.alone, 32'd0);
    endcase
    return r;
  endfunction

  // First character of a new token, from idle.
  function automatic start_t start_char(input logic [7:0] c);
    start_t r;
    r.sc = SCAN_IDLE;
    r.ot = '0;
    if (c == " " || c inside {[8'd9:8'd13]}) begin
      r.ot = '0;
    end else if (is_letter(c)) begin
      r.sc.st   = S_WORD;
      r.sc.wcnt = 8'd1;
    end else if (c == "0") begin
      r.sc.st = S_ZERO;
    end else if (is_digit(c)) begin
      r.sc.st  = S_DEC;
      r.sc.acc = {28'd0, c[3:0]};
    end else begin
      case (c)
        "+":     r.sc.st = S_PLUS;
        "-":     r.sc.st = S_MINUS;
        "*":     r.sc.st = S_STAR;
        "/":     r.sc.st = S_SLASH;
        "%":     r.sc.st = S_PERCENT;
        "=":     r.sc.st = S_EQ;
        "!":     r.sc.st = S_BANG;
        ">":     r.sc.st = S_GT;
        "<":     r.sc.st = S_LT;
        "&":     r.sc.st = S_AMP;
        "|":     r.sc.st = S_BAR;
        "^":     r.sc.st = S_CARET;
        ".":     r.sc.st = S_DOT;
        "#":     r.sc.st = S_HASH;
        "~":     r.ot = mk_tok(K_TILDE, 32'd0);
        ";":     r.ot = mk_tok(K_SEMI, 32'd0);
        "?":     r.ot = mk_tok(K_QUEST, 32'd0);
        ":":     r.ot = mk_tok(K_COLON, 32'd0);
        ",":     r.ot = mk_tok(K_COMMA, 32'd0);
        "{":     r.ot = mk_tok(K_LBRACE, 32'd0);
        "}":     r.ot = mk_tok(K_RBRACE, 32'd0);
        "[":     r.ot = mk_tok(K_LBRACK, 32'd0);
        "]":     r.ot = mk_tok(K_RBRACK, 32'd0);
        "(":     r.ot = mk_tok(K_LPAREN, 32'd0);
        ")":     r.ot = mk_tok(K_RPAREN, 32'd0);
        default: r.ot = mk_tok(K_ERR_CHAR, {24'd0, c});
      endcase
    end
    return r;
  endfunction

  state_t   s_eff;
  logic     brk;
  opt_tok_t emit_tok;
  opt_tok_t pend;
  start_t   stc;
  op_rule_t rule;
  logic     hex_ok;
  logic [3:0] hex_d;

  always_comb begin
    nxt      = cur;
    s_eff    = cur.st;
    brk      = 1'b0;
    emit_tok = '0;
    rule     = op_rule(cur.st);
    stc      = start_char(ch);
    hex_ok   = 1'b1;
    hex_d    = ch[3:0];
    if (is_digit(ch)) begin
      hex_d = ch[3:0];
    end else if (ch inside {["a":"f"], ["A":"F"]}) begin
      hex_d = ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end

    if (!eos) begin
      if (cur.st == S_ZERO && (ch == "x" || ch == "X")) begin
        nxt.st = S_HEX;
      end else begin
        if (cur.st == S_ZERO) begin
          s_eff  = S_OCT;
          nxt.st = S_OCT;
        end
        case (s_eff)
          S_IDLE: brk = 1'b1;
          S_WORD: begin
            if (is_letter(ch) || is_digit(ch)) begin
              if (cur.wcnt != 8'hFF) nxt.wcnt = cur.wcnt + 8'd1;
            end else begin
              brk = 1'b1;
            end
          end
          S_DEC: begin
            if (ch == "'") begin
              nxt = cur;
            end else if (is_digit(ch)) begin
              nxt.acc = mac10(cur.acc, ch[3:0]);
            end else if (ch == ".") begin
              nxt.st = S_FRAC;
            end else begin
              brk = 1'b1;
            end
          end
          S_FRAC: begin
            if (is_digit(ch)) begin
              if (cur.frac < MAX_FRACTION_DIGITS) begin
                nxt.acc  = mac10(cur.acc, ch[3:0]);
                nxt.frac = cur.frac + 4'd1;
              end
            end else begin
              brk = 1'b1;
            end
          end
          S_OCT: begin
            if (ch == "'") begin
              nxt.st = S_OCT;
            end else if (ch inside {["0":"7"]}) begin
              nxt.acc = {cur.acc[28:0], ch[2:0]};
            end else begin
              brk = 1'b1;
            end
          end
          S_HEX: begin
            if (ch == "'") begin
              nxt = cur;
            end else if (hex_ok) begin
              nxt.acc = {cur.acc[27:0], hex_d};
            end else begin
              brk = 1'b1;
            end
          end
          S_LINE: begin
            if (ch == "\n") nxt = SCAN_IDLE;
          end
          S_BLOCK: begin
            if (cur.pws && ch == "/") nxt = SCAN_IDLE;
            else nxt.pws = (ch == "*");
          end
          default: begin
            if ((s_eff == S_PLUS || s_eff == S_MINUS) && is_digit(ch)) begin
              nxt.neg = (s_eff == S_MINUS);
              nxt.st  = S_DEC;
              nxt.acc = {28'd0, ch[3:0]};
            end else if (s_eff == S_SLASH && ch == "/") begin
              nxt.st = S_LINE;
            end else if (s_eff == S_SLASH && ch == "*") begin
              nxt.st  = S_BLOCK;
              nxt.pws = 1'b0;
            end else if (s_eff == S_GT && ch == ">") begin
              nxt.st = S_GTGT;
            end else if (s_eff == S_LT && ch == "<") begin
              nxt.st = S_LTLT;
            end else if (s_eff == S_DOT && is_digit(ch)) begin
              nxt.st   = S_FRAC;
              nxt.acc  = {28'd0, ch[3:0]};
              nxt.frac = 4'd1;
            end else if (rule.h1 && ch == rule.c1) begin
              emit_tok = mk_tok(rule.k1, 32'd0);
              nxt      = SCAN_IDLE;
            end else if (rule.h2 && ch == rule.c2) begin
              emit_tok = mk_tok(rule.k2, 32'd0);
              nxt      = SCAN_IDLE;
            end else begin
              brk = 1'b1;
            end
          end
        endcase
      end
    end

    pend = flush_tok(cur, s_eff);
    tok0 = '0;
    tok1 = '0;
    tok_n = 2'd0;
    if (eos) begin
      // Flush the pending token, then close the stream.
      nxt = SCAN_IDLE;
      if (pend.valid) begin
        tok0  = pend.tok;
        tok1  = '{kind: K_END, value: 32'd0, scale: 4'd0, word_length: 8'd0};
        tok_n = 2'd2;
      end else begin
        tok0  = '{kind: K_END, value: 32'd0, scale: 4'd0, word_length: 8'd0};
        tok_n = 2'd1;
      end
    end else if (brk) begin
      nxt = stc.sc;
      if (pend.valid && stc.ot.valid) begin
        tok0  = pend.tok;
        tok1  = stc.ot.tok;
        tok_n = 2'd2;
      end else if (pend.valid) begin
        tok0  = pend.tok;
        tok_n = 2'd1;
      end else if (stc.ot.valid) begin
        tok0  = stc.ot.tok;
        tok_n = 2'd1;
      end
    end else if (emit_tok.valid) begin
      tok0  = emit_tok.tok;
      tok_n = 2'd1;
    end
  end

endmodule

/* rtl/core/c_style_token_scanner_core.sv */
// Top level of the C-style token scanner: input register, scan state and token queue.
//
// Streams one character word per cycle in and C tokens out. Each input word
// carries a byte in in_tdata and the end-of-stream flag in in_tuser; an
// end-of-stream word flushes any pending token and then emits the END token.
// The scanner state (token class, 32-bit accumulator, sign, fraction count,
// word length, block-comment star flag) updates once per character, so the
// sustained input rate is one word per clock as long as tokens are drained.
// A character produces zero, one or two tokens; tokens land in a four-entry
// queue, and a registered input word is consumed only when the queue has
// room for two tokens, so a character that yields two tokens may
// back-pressure the input when the output side is slow. An accepted word
// passes through the input register and the token queue before its first
// token is offered. The token kind is on out_tuser, out_tlast marks the last
// token produced by one input word. Reals are reported as mantissa in value
// and decimal scale in scale; numbers wrap at 32 bits.
module c_style_token_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] value, [35:32] scale, [43:36] word_length, rest 0
  output logic [5:0]  out_tuser,  // [5:0] kind
  output logic        out_tlast   // last token of its input word
);
  import ctsc_pkg::*;

  // Input register.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] ch_r;
  logic       eos_r;

  // Scanner state.
  scan_t scan_r, scan_nxt;

  // Token queue.
  qword_t             q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  token_t     tok0, tok1;
  logic [1:0] tok_n;
  logic       step;
  logic       pop;
  qword_t     head;

  ctsc_scanner u_scanner (
    .cur   (scan_r),
    .ch    (ch_r),
    .eos   (eos_r),
    .nxt   (scan_nxt),
    .tok0  (tok0),
    .tok1  (tok1),
    .tok_n (tok_n)
  );

  // Advance the registered word only when two queue slots are free.
  assign step      = in_valid_r && (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_tready = !in_valid_r || step;
  assign pop       = out_tvalid && out_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (step)              in_valid_nxt = 1'b0;

    wr_ptr_nxt = wr_ptr_r;
    if (step) wr_ptr_nxt = wr_ptr_r + QPTR_W'(tok_n);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (step ? QCNT_W'(tok_n) : QCNT_W'(0)) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      scan_r     <= SCAN_IDLE;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
      if (step) scan_r <= scan_nxt;
    end
  end

  // Hold payload; no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r  <= in_tdata;
      eos_r <= in_tuser;
    end
    if (step && tok_n != 2'd0) begin
      q_r[wr_ptr_r] <= '{tok: tok0, last: (tok_n == 2'd1)};
    end
    if (step && tok_n == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= '{tok: tok1, last: 1'b1};
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = head.tok.kind;
  assign out_tdata  = {4'd0, head.tok.word_length, head.tok.scale, head.tok.value};
  assign out_tlast  = head.last;

endmodule

/* rtl/core/ctsc_checker.sv */
// Port-level checks of the C-style token scanner, bound to its top level.
module ctsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [5:0]  out_tuser,
  input logic        out_tlast
);
  import ctsc_pkg::*;

  // A stalled token stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("token dropped while stalled");

  // END always closes the tokens of its input word.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_END |-> out_tlast)
    else $error("END token not marked last");

  // A word always has at least one character.
  a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_WORD |-> out_tdata[43:36] != 8'd0)
    else $error("word token with zero length");

  // Only numbers and bad characters carry a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != K_INT && out_tuser != K_REAL && out_tuser != K_ERR_CHAR
    |-> out_tdata[31:0] == 32'd0)
    else $error("non-numeric token carries a value");

  // Scale belongs to reals and never exceeds the fraction limit.
  a_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == K_REAL && out_tdata[35:32] <= MAX_FRACTION_DIGITS)
                   || out_tdata[35:32] == 4'd0)
    else $error("bad scale on token");

endmodule

bind c_style_token_scanner_core ctsc_checker u_ctsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
